### src/ssi_pkg.sv
// shared widths, constants and types for the segment and sphere intersection pipeline
package ssi_pkg;

	localparam int COORD_BITS      = 24;
	localparam int RADIUS_BITS     = 23;
	localparam int ALPHA_FRAC_BITS = 16;
	localparam int ALPHA_BITS      = ALPHA_FRAC_BITS + 1;

	localparam int IN_FIELDS_BITS  = 9 * COORD_BITS + RADIUS_BITS;
	localparam int IN_BITS         = ((IN_FIELDS_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_BITS = 2 + 2 * ALPHA_BITS;
	localparam int OUT_BITS        = ((OUT_FIELDS_BITS + 7) / 8) * 8;

	localparam int DW    = COORD_BITS + 1;
	localparam int PW    = 2 * DW;
	localparam int RRW   = 2 * RADIUS_BITS;
	localparam int QW    = PW + 4;
	localparam int HW    = QW / 2;
	localparam int PPW   = 2 * HW + 2;
	localparam int DISCW = 2 * QW + 2;
	localparam int GW    = QW + 2 * ALPHA_FRAC_BITS + 6;

	typedef struct packed {
		logic start_in;
		logic azero;
		logic t_ok;
		logic disc_neg;
	} ssi_flags_t;

endpackage

### src/segment_sphere_intersect.sv
// Segment against sphere intersection test as a fully pipelined datapath. Each transaction on
// s_tdata carries a segment start and end point, a sphere center and a radius; one result
// transaction on m_tdata follows for each, in order. A new transaction can be taken in every
// cycle unless m_tready back-pressure has filled the pipeline. The result passes 24 registers:
// six stages form the quadratic coefficients and the sign of its discriminant, seventeen
// shift-and-add stages find the entry and exit parameters one bit each, and one output
// register holds the result. Entry and exit are floor(t * 65536) clamped to [0, 65536];
// both are zero on a miss or for a zero-length segment, and entry is zero when the start point
// lies inside or on the sphere.
module segment_sphere_intersect (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y, center_z, radius
	input  logic [ssi_pkg::IN_BITS-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// hit, starts_inside, enter_alpha, exit_alpha
	output logic [ssi_pkg::OUT_BITS-1:0] m_tdata
);
	import ssi_pkg::*;

	localparam int F = ALPHA_FRAC_BITS;

	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [DW-1:0]  d_s1 [3];
	logic signed [DW-1:0]  o_s1 [3];
	logic [RADIUS_BITS-1:0] r_s1;

	logic signed [PW-1:0]  dd_s2 [3];
	logic signed [PW-1:0]  od_s2 [3];
	logic signed [PW-1:0]  oo_s2 [3];
	logic [RRW-1:0]         rr_s2;

	logic signed [QW-1:0]  a_s3, b_s3, c_s3;

	logic signed [QW-1:0]  a_s4, b_s4, c_s4;
	logic signed [PPW-1:0] bb_hh_s4, bb_hl_s4, bb_ll_s4;
	logic signed [PPW-1:0] ac_hh_s4, ac_hl_s4, ac_lh_s4, ac_ll_s4;
	ssi_flags_t            f_s4;

	logic signed [QW-1:0]  a_s5, b_s5, c_s5;
	logic signed [DISCW-1:0] bb_s5, ac_s5;
	ssi_flags_t            f_s5;

	logic signed [QW-1:0]  a_s6, b_s6, c_s6;
	ssi_flags_t            f_s6;

	logic                  v_sb     [F+1];
	logic                  rdy_b    [F+1];
	logic [ALPHA_BITS-1:0] k_en_sb  [F+1];
	logic [ALPHA_BITS-1:0] k_ex_sb  [F+1];
	logic signed [GW-1:0]  g_en_sb  [F+1];
	logic signed [GW-1:0]  h_en_sb  [F+1];
	logic signed [GW-1:0]  g_ex_sb  [F+1];
	logic signed [GW-1:0]  h_ex_sb  [F+1];
	logic signed [QW-1:0]  a_sb     [F+1];
	ssi_flags_t            f_sb     [F+1];

	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	// ready chain, a stage moves when it is empty or its successor moves
	assign rdy_out  = ~out_valid_q | m_tready;
	assign rdy6     = ~v_s6 | rdy_b[0];
	assign rdy5     = ~v_s5 | rdy6;
	assign rdy4     = ~v_s4 | rdy5;
	assign rdy3     = ~v_s3 | rdy4;
	assign rdy2     = ~v_s2 | rdy3;
	assign rdy1     = ~v_s1 | rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: direction and offset
	logic signed [DW-1:0] d_c [3];
	logic signed [DW-1:0] o_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = DW'($signed(s_tdata[(3 + i) * COORD_BITS +: COORD_BITS]))
				- DW'($signed(s_tdata[i * COORD_BITS +: COORD_BITS]));
			o_c[i] = DW'($signed(s_tdata[i * COORD_BITS +: COORD_BITS]))
				- DW'($signed(s_tdata[(6 + i) * COORD_BITS +: COORD_BITS]));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_s1 <= d_c;
			o_s1 <= o_c;
			r_s1 <= s_tdata[9 * COORD_BITS +: RADIUS_BITS];
		end
	end

	// stage 2: coordinate products
	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= PW'(d_s1[i]) * PW'(d_s1[i]);
				od_s2[i] <= PW'(o_s1[i]) * PW'(d_s1[i]);
				oo_s2[i] <= PW'(o_s1[i]) * PW'(o_s1[i]);
			end
			rr_s2 <= RRW'(r_s1) * RRW'(r_s1);
		end
	end

	// stage 3: quadratic coefficients
	always_ff @(posedge clk) begin
		if (rdy3) begin
			a_s3 <= QW'(dd_s2[0]) + QW'(dd_s2[1]) + QW'(dd_s2[2]);
			b_s3 <= QW'(od_s2[0]) + QW'(od_s2[1]) + QW'(od_s2[2]);
			c_s3 <= QW'(oo_s2[0]) + QW'(oo_s2[1]) + QW'(oo_s2[2])
				- QW'($signed({1'b0, rr_s2}));
		end
	end

	// stage 4: discriminant partial products and range flags
	logic signed [HW-1:0]   ah, bh, ch;
	logic signed [HW:0]     alx, blx, clx;
	logic signed [QW+1:0]   sum_ba, sum_f1;
	logic                   inside_c, t1_ok_c, t2_ok_c;

	always_comb begin
		ah       = a_s3[QW-1:HW];
		bh       = b_s3[QW-1:HW];
		ch       = c_s3[QW-1:HW];
		alx      = $signed({1'b0, a_s3[HW-1:0]});
		blx      = $signed({1'b0, b_s3[HW-1:0]});
		clx      = $signed({1'b0, c_s3[HW-1:0]});
		sum_ba   = (QW+2)'(b_s3) + (QW+2)'(a_s3);
		sum_f1   = (QW+2)'(a_s3) + ((QW+2)'(b_s3) <<< 1) + (QW+2)'(c_s3);
		inside_c = c_s3[QW-1] | (c_s3 == '0);
		t2_ok_c  = inside_c | b_s3[QW-1] | (b_s3 == '0);
		t1_ok_c  = ~sum_ba[QW+1] | sum_f1[QW+1] | (sum_f1 == '0);
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			a_s4            <= a_s3;
			b_s4            <= b_s3;
			c_s4            <= c_s3;
			bb_hh_s4        <= PPW'(bh) * PPW'(bh);
			bb_hl_s4        <= PPW'(bh) * PPW'(blx);
			bb_ll_s4        <= PPW'(blx) * PPW'(blx);
			ac_hh_s4        <= PPW'(ah) * PPW'(ch);
			ac_hl_s4        <= PPW'(ah) * PPW'(clx);
			ac_lh_s4        <= PPW'(alx) * PPW'(ch);
			ac_ll_s4        <= PPW'(alx) * PPW'(clx);
			f_s4.start_in   <= inside_c;
			f_s4.azero      <= (a_s3 == '0);
			f_s4.t_ok       <= t1_ok_c & t2_ok_c;
			f_s4.disc_neg   <= 1'b0;
		end
	end

	// stage 5: b*b and a*c
	always_ff @(posedge clk) begin
		if (rdy5) begin
			a_s5  <= a_s4;
			b_s5  <= b_s4;
			c_s5  <= c_s4;
			f_s5  <= f_s4;
			bb_s5 <= (DISCW'(bb_hh_s4) <<< (2 * HW)) + (DISCW'(bb_hl_s4) <<< (HW + 1))
				+ DISCW'(bb_ll_s4);
			ac_s5 <= (DISCW'(ac_hh_s4) <<< (2 * HW))
				+ ((DISCW'(ac_hl_s4) + DISCW'(ac_lh_s4)) <<< HW) + DISCW'(ac_ll_s4);
		end
	end

	// stage 6: discriminant sign
	logic signed [DISCW-1:0] disc_c;
	assign disc_c = bb_s5 - ac_s5;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			a_s6          <= a_s5;
			b_s6          <= b_s5;
			c_s6          <= c_s5;
			f_s6.start_in <= f_s5.start_in;
			f_s6.azero    <= f_s5.azero;
			f_s6.t_ok     <= f_s5.t_ok;
			f_s6.disc_neg <= disc_c[DISCW-1];
		end
	end

	// root search, one bit of the parameter per stage, both roots side by side
	for (genvar i = 0; i <= F; i++) begin : g_bis
		localparam int SH = (i == 0) ? F : F - i;

		logic                  v_in, rdy_nx;
		logic [ALPHA_BITS-1:0] k_en_in, k_ex_in, k_cand;
		logic signed [GW-1:0]  g_en_in, h_en_in, g_ex_in, h_ex_in;
		logic signed [GW-1:0]  g_en_c, h_en_c, g_ex_c, h_ex_c, a_sh;
		logic signed [QW-1:0]  a_in;
		ssi_flags_t            f_in;
		logic                  ok_en, ok_ex;

		if (i == 0) begin : g_first
			assign v_in    = v_s6;
			assign k_en_in = '0;
			assign k_ex_in = '0;
			assign g_en_in = GW'(c_s6) <<< (2 * F);
			assign g_ex_in = GW'(c_s6) <<< (2 * F);
			assign h_en_in = GW'(b_s6) <<< F;
			assign h_ex_in = GW'(b_s6) <<< F;
			assign a_in    = a_s6;
			assign f_in    = f_s6;
		end else begin : g_next
			assign v_in    = v_sb[i-1];
			assign k_en_in = k_en_sb[i-1];
			assign k_ex_in = k_ex_sb[i-1];
			assign g_en_in = g_en_sb[i-1];
			assign g_ex_in = g_ex_sb[i-1];
			assign h_en_in = h_en_sb[i-1];
			assign h_ex_in = h_ex_sb[i-1];
			assign a_in    = a_sb[i-1];
			assign f_in    = f_sb[i-1];
		end

		if (i == F) begin : g_last
			assign rdy_nx = rdy_out;
		end else begin : g_mid
			assign rdy_nx = rdy_b[i+1];
		end

		assign rdy_b[i] = ~v_sb[i] | rdy_nx;

		always_comb begin
			a_sh   = GW'(a_in) <<< SH;
			k_cand = k_en_in + (ALPHA_BITS'(1) << SH);
			h_en_c = h_en_in + a_sh;
			g_en_c = g_en_in + (h_en_in <<< (SH + 1)) + (GW'(a_in) <<< (2 * SH));
			h_ex_c = h_ex_in + a_sh;
			g_ex_c = g_ex_in + (h_ex_in <<< (SH + 1)) + (GW'(a_in) <<< (2 * SH));
			ok_en  = ~g_en_c[GW-1] & (h_en_c[GW-1] | (h_en_c == '0));
			ok_ex  = g_ex_c[GW-1] | (g_ex_c == '0) | h_ex_c[GW-1] | (h_ex_c == '0);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sb[i] <= 1'b0;
			end else if (rdy_b[i]) begin
				v_sb[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_b[i]) begin
				a_sb[i] <= a_in;
				f_sb[i] <= f_in;
				if (ok_en && !k_en_in[F]) begin
					k_en_sb[i] <= k_cand;
					g_en_sb[i] <= g_en_c;
					h_en_sb[i] <= h_en_c;
				end else begin
					k_en_sb[i] <= k_en_in;
					g_en_sb[i] <= g_en_in;
					h_en_sb[i] <= h_en_in;
				end
				if (ok_ex && !k_ex_in[F]) begin
					k_ex_sb[i] <= k_ex_in + (ALPHA_BITS'(1) << SH);
					g_ex_sb[i] <= g_ex_c;
					h_ex_sb[i] <= h_ex_c;
				end else begin
					k_ex_sb[i] <= k_ex_in;
					g_ex_sb[i] <= g_ex_in;
					h_ex_sb[i] <= h_ex_in;
				end
			end
		end
	end

	// result register
	ssi_flags_t            f_end;
	logic                  hit_c, span_c;
	logic [ALPHA_BITS-1:0] enter_c, exit_c;

	always_comb begin
		f_end   = f_sb[F];
		span_c  = ~f_end.azero & ~f_end.disc_neg & f_end.t_ok;
		hit_c   = f_end.azero ? f_end.start_in : span_c;
		enter_c = (span_c && !f_end.start_in) ? k_en_sb[F] : '0;
		exit_c  = span_c ? k_ex_sb[F] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_sb[F];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_data_q <= OUT_BITS'({exit_c, enter_c, f_end.start_in, hit_c});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### src/ssi_checker.sv
// port-level checks for the segment and sphere intersection block, with its bind
module ssi_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [ssi_pkg::IN_BITS-1:0]  s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ssi_pkg::OUT_BITS-1:0] m_tdata
);
	import ssi_pkg::*;

	localparam int EN_LO = 2;
	localparam int EX_LO = 2 + ALPHA_BITS;

	logic [ALPHA_BITS-1:0] enter_w, exit_w;
	logic                  in_seen;

	assign enter_w = m_tdata[EN_LO +: ALPHA_BITS];
	assign exit_w  = m_tdata[EX_LO +: ALPHA_BITS];
	assign in_seen = s_tvalid & s_tready & (s_tdata != '0 || s_tdata == '0);

	// stalled result transaction is held
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result transaction dropped or changed under stall");

	// a miss carries no parameters
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> enter_w == '0 && exit_w == '0)
		else $error("miss with nonzero parameters");

	// start inside means entry at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> enter_w == '0)
		else $error("start inside with nonzero entry");

	// entry never lies past exit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> enter_w <= exit_w)
		else $error("entry after exit");

	// exit parameter stays within one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid || in_seen |-> exit_w <= (ALPHA_BITS'(1) << ALPHA_FRAC_BITS)
			|| !m_tvalid)
		else $error("exit parameter above one");

endmodule

bind segment_sphere_intersect ssi_checker u_ssi_checker (.*);
